### rtl/dtq_pkg.sv
// Package for the deadline timer queue: item kinds, result status codes
// and the control state encoding. No dependencies.
`timescale 1ns / 1ps
package dtq_pkg;
  typedef enum logic [1:0] {
    KIND_RESERVE = 2'd0,
    KIND_RELEASE = 2'd1,
    KIND_CLEAR   = 2'd2,
    KIND_NONE    = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ST_ACCEPTED = 2'd0,
    ST_FULL     = 2'd1,
    ST_RELEASED = 2'd2,
    ST_EMPTY    = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS_RD,
    S_INS_CHK,
    S_REL_RD,
    S_REL_CHK,
    S_CMP_RD,
    S_CMP_WR,
    S_OUT
  } state_e;

  localparam int unsigned MaxResults = 32;
  localparam int unsigned TickBits = 48;
  localparam int unsigned DataW = TickBits + 32 + 16;
endpackage

### rtl/dtq_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
module dtq_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

### rtl/deadline_timer_queue.sv
// Top level of the deadline timer queue: stream ports, sequencer and the
// entry memory (dtq_ram). Depends on dtq_pkg.
`timescale 1ns / 1ps
// Entries are held sorted by deadline in one memory of CAPACITY words, equal
// deadlines in reserve order. Clear, unused kind, full and a reserve into an
// empty queue answer in the cycle after the input beat. Any other reserve
// scans down from the tail, moving each later entry up one slot through a
// read and a check state, and answers once the new entry is written. A release
// reads due entries from the head, a read and a check state each; each result
// beat is loaded only after the next entry has been checked, so tlast is final
// when the beat appears, and a stalled output holds the scan. A release with
// nothing due answers after its read and check states (in the cycle after its
// beat if the queue is empty). Remaining entries are then compacted down, a
// read and a write state each. One item is in work at a time; a new
// item is taken once the sequencer is idle and the last result beat has left.
module deadline_timer_queue
  import dtq_pkg::*;
#(
  parameter int unsigned CAPACITY  = 32
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // [47:0] now_tick, [79:48] delay_ticks, [111:80] job_handle,
  // [127:112] owner_handle
  input  logic [127:0] s_axis_tdata,
  // kind
  input  logic [1:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [31:0] job_out, [47:32] owner_out, [95:48] deadline_out
  output logic [95:0]  m_axis_tdata,
  // status
  output logic [1:0]   m_axis_tuser,
  output logic         m_axis_tlast
);
  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned NLimit = (CAPACITY < MaxResults) ? CAPACITY : MaxResults;
  localparam logic [TickBits-1:0] TMax = '1;

  state_e state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d, idx_q, idx_d, n_q, n_d;
  logic [TickBits-1:0] now_q, now_d, dl_q, dl_d;
  logic [31:0] job_q, job_d;
  logic [15:0] own_q, own_d;
  logic [1:0] ost_q, ost_d;
  logic [95:0] odat_q, odat_d;
  logic olast_q, olast_d, ovalid_q, ovalid_d;

  logic we;
  logic [AW-1:0] waddr, raddr;
  logic [DataW-1:0] wdata, rdata;
  logic [TickBits-1:0] r_dl, now_in, sum_lo;
  logic [TickBits:0] sum;
  logic out_free, rel_due, rel_more;
  logic [CW-1:0] idx_nx, n_nx;

  assign r_dl = rdata[TickBits-1:0];
  assign now_in = s_axis_tdata[TickBits-1:0];
  assign sum = {1'b0, now_in} + {{(TickBits+1-32){1'b0}}, s_axis_tdata[79:48]};
  assign sum_lo = sum[TickBits] ? TMax : sum[TickBits-1:0];

  assign out_free = !ovalid_q || m_axis_tready;
  assign idx_nx = idx_q + CW'(1);
  assign n_nx = n_q + CW'(1);
  assign rel_due = (r_dl <= now_q) && (n_q < CW'(NLimit));
  assign rel_more = (idx_nx < cnt_q) && (n_nx < CW'(NLimit));

  dtq_ram #(.Width(DataW), .Depth(CAPACITY)) u_ram (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(raddr), .rdata_o(rdata)
  );

  assign s_axis_tready = (state_q == S_IDLE) && !ovalid_q;
  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata = odat_q;
  assign m_axis_tuser = ost_q;
  assign m_axis_tlast = olast_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid && s_axis_tready) begin
          if (s_axis_tuser == KIND_RESERVE && cnt_q < CW'(CAPACITY)
              && cnt_q != '0) begin
            state_d = S_INS_RD;
          end else if (s_axis_tuser == KIND_RELEASE && cnt_q != '0) begin
            state_d = S_REL_RD;
          end
        end
      end
      S_INS_RD: begin
        if (idx_q == '0) state_d = S_IDLE;
        else state_d = S_INS_CHK;
      end
      S_INS_CHK: begin
        if (r_dl <= dl_q) state_d = S_IDLE;
        else state_d = S_INS_RD;
      end
      S_REL_RD: state_d = S_REL_CHK;
      S_REL_CHK: begin
        if (n_q == '0) begin
          if (!rel_due) state_d = S_IDLE;
          else if (rel_more) state_d = S_REL_RD;
          else state_d = S_OUT;
        end else if (out_free) begin
          if (!rel_due) state_d = S_CMP_RD;
          else if (rel_more) state_d = S_REL_RD;
          else state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (out_free) begin
          if (idx_q < cnt_q) state_d = S_CMP_RD;
          else state_d = S_IDLE;
        end
      end
      S_CMP_RD: state_d = S_CMP_WR;
      S_CMP_WR: begin
        if (idx_q + CW'(1) < cnt_q) state_d = S_CMP_RD;
        else state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cnt_d = cnt_q; idx_d = idx_q; n_d = n_q; now_d = now_q; dl_d = dl_q;
    job_d = job_q; own_d = own_q;
    ost_d = ost_q; odat_d = odat_q; olast_d = olast_q;
    ovalid_d = ovalid_q && !m_axis_tready;
    we = 1'b0; waddr = '0; wdata = {DataW{1'b0}}; raddr = '0;
    case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid && s_axis_tready) begin
          now_d = now_in; dl_d = sum_lo;
          job_d = s_axis_tdata[111:80]; own_d = s_axis_tdata[127:112];
          idx_d = cnt_q; n_d = '0;
          ost_d = ST_EMPTY; odat_d = '0; olast_d = 1'b1; ovalid_d = 1'b1;
          case (s_axis_tuser)
            KIND_RESERVE: begin
              if (cnt_q >= CW'(CAPACITY)) begin
                ost_d = ST_FULL;
              end else begin
                ost_d = ST_ACCEPTED;
                cnt_d = cnt_q + CW'(1);
                if (cnt_q == '0) begin
                  we = 1'b1;
                  wdata = {s_axis_tdata[127:112], s_axis_tdata[111:80],
                           48'(sum_lo)};
                end else begin
                  ovalid_d = 1'b0;
                end
              end
            end
            KIND_RELEASE: begin
              if (cnt_q != '0) begin
                ovalid_d = 1'b0; idx_d = '0;
              end
            end
            KIND_CLEAR: cnt_d = '0;
            default: ;
          endcase
        end
      end
      S_INS_RD: begin
        if (idx_q == '0) begin
          we = 1'b1;
          waddr = '0;
          wdata = {own_q, job_q, 48'(dl_q)};
          ovalid_d = 1'b1;
        end else begin
          raddr = AW'(idx_q - CW'(1));
        end
      end
      S_INS_CHK: begin
        we = 1'b1;
        waddr = AW'(idx_q);
        if (r_dl <= dl_q) begin
          wdata = {own_q, job_q, 48'(dl_q)};
          ovalid_d = 1'b1;
        end else begin
          wdata = rdata;
          idx_d = idx_q - CW'(1);
        end
      end
      S_REL_RD: raddr = AW'(idx_q);
      S_REL_CHK: begin
        // hold the read address so a stalled check sees the same entry
        raddr = AW'(idx_q);
        if (n_q == '0) begin
          if (rel_due) begin
            job_d = rdata[79:48]; own_d = rdata[95:80]; dl_d = r_dl;
            idx_d = idx_nx; n_d = n_nx;
          end else begin
            ost_d = ST_EMPTY; odat_d = '0; olast_d = 1'b1; ovalid_d = 1'b1;
          end
        end else if (out_free) begin
          ovalid_d = 1'b1; ost_d = ST_RELEASED;
          odat_d = {48'(dl_q), own_q, job_q};
          olast_d = !rel_due;
          if (rel_due) begin
            job_d = rdata[79:48]; own_d = rdata[95:80]; dl_d = r_dl;
            idx_d = idx_nx; n_d = n_nx;
          end
        end
      end
      S_OUT: begin
        if (out_free) begin
          ovalid_d = 1'b1; ost_d = ST_RELEASED;
          odat_d = {48'(dl_q), own_q, job_q};
          olast_d = 1'b1;
          if (idx_q >= cnt_q) cnt_d = '0;
        end
      end
      S_CMP_RD: raddr = AW'(idx_q);
      S_CMP_WR: begin
        we = 1'b1; waddr = AW'(idx_q - n_q); wdata = rdata;
        idx_d = idx_q + CW'(1);
        if (idx_q + CW'(1) >= cnt_q) cnt_d = cnt_q - n_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; cnt_q <= '0; ovalid_q <= 1'b0;
      idx_q <= '0; n_q <= '0;
    end else begin
      state_q <= state_d; cnt_q <= cnt_d; idx_q <= idx_d; n_q <= n_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    now_q <= now_d; dl_q <= dl_d; job_q <= job_d; own_q <= own_d;
    ost_q <= ost_d; odat_q <= odat_d;
    olast_q <= olast_d;
  end

`ifndef SYNTHESIS
  a_cnt_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(CAPACITY)) else $error("count over capacity");
  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> state_q == S_IDLE) else $error("ready while busy");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovalid_q && !m_axis_tready |=> ovalid_q) else $error("beat dropped");
`endif
endmodule

### dv/tb_deadline_timer_queue.sv
// Testbench for deadline_timer_queue: drives reserve, release, clear and unused-kind beats,
// predicts every result beat and compares it field by field. Depends on dtq_pkg.
`timescale 1ns / 1ps
module tb_deadline_timer_queue
  import dtq_pkg::*;
();

  localparam int unsigned Cap = 32;
  localparam logic [47:0] TickMax = 48'hFFFF_FFFF_FFFF;
  localparam int unsigned StallLimit = 20000;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] job;
    logic [15:0] owner;
    logic [47:0] deadline;
    logic        last;
  } beat_t;

  typedef struct {
    logic [47:0] deadline;
    logic [31:0] job;
    logic [15:0] owner;
  } timer_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [127:0] s_axis_tdata = '0;
  logic [1:0]   s_axis_tuser = KIND_NONE;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [95:0]  m_axis_tdata;
  logic [1:0]   m_axis_tuser;
  logic         m_axis_tlast;

  timer_t      pending_timers[$];
  beat_t       expected_beats[$];
  int          error_count = 0;
  int          beats_checked = 0;
  int          items_sent = 0;
  int          idle_pct = 28;
  int          stall_cycles = 0;
  logic [47:0] clock_now = 48'd1000;

  deadline_timer_queue uut (.*);

  always #2 clk_i = ~clk_i;

  task automatic report_mismatch(input string what);
    $display("mismatch at beat %0d: %s", beats_checked, what);
    error_count++;
  endtask

  task automatic add_expected(input beat_t b);
    expected_beats.insert(expected_beats.size(), b);
  endtask

  // Predict the result beats of one item and update the shadow queue.
  task automatic predict_timer_item(input kind_e kind, input logic [47:0] now,
                                    input logic [31:0] delay, input logic [31:0] job,
                                    input logic [15:0] owner);
    logic [48:0] sum;
    timer_t      t;
    int          pos;
    int          n;
    beat_t       b;
    b = '{status: ST_EMPTY, job: '0, owner: '0, deadline: '0, last: 1'b1};
    case (kind)
      KIND_RESERVE: begin
        if (pending_timers.size() >= Cap) begin
          b.status = ST_FULL;
        end else begin
          sum = {1'b0, now} + {17'd0, delay};
          t.deadline = sum[48] ? TickMax : sum[47:0];
          t.job = job;
          t.owner = owner;
          pos = pending_timers.size();
          while (pos > 0 && pending_timers[pos-1].deadline > t.deadline) pos--;
          pending_timers.insert(pos, t);
          b.status = ST_ACCEPTED;
        end
        add_expected(b);
      end
      KIND_RELEASE: begin
        n = 0;
        while (n < pending_timers.size() && n < MaxResults &&
               pending_timers[n].deadline <= now) n++;
        if (n == 0) add_expected(b);
        for (int i = 0; i < n; i++) begin
          t = pending_timers.pop_front();
          b.status = ST_RELEASED;
          b.job = t.job;
          b.owner = t.owner;
          b.deadline = t.deadline;
          b.last = (i == n - 1);
          add_expected(b);
        end
      end
      KIND_CLEAR: begin
        pending_timers.delete();
        add_expected(b);
      end
      default: add_expected(b);
    endcase
  endtask

  task automatic send_item(input kind_e kind, input logic [47:0] now,
                           input logic [31:0] delay, input logic [31:0] job,
                           input logic [15:0] owner);
    while ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= kind;
    s_axis_tdata <= {owner, job, delay, now};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    predict_timer_item(kind, now, delay, job, owner);
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    do @(negedge clk_i); while (expected_beats.size() != 0);
  endtask

  always @(posedge clk_i) begin
    beat_t got;
    beat_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = '{status: m_axis_tuser, job: m_axis_tdata[31:0], owner: m_axis_tdata[47:32],
              deadline: m_axis_tdata[95:48], last: m_axis_tlast};
      if (expected_beats.size() == 0) begin
        report_mismatch("result beat with nothing expected");
      end else begin
        want = expected_beats.pop_front();
        if (got.status !== want.status)
          report_mismatch($sformatf("status %0d want %0d", got.status, want.status));
        if (got.job !== want.job)
          report_mismatch($sformatf("job %h want %h", got.job, want.job));
        if (got.owner !== want.owner)
          report_mismatch($sformatf("owner %h want %h", got.owner, want.owner));
        if (got.deadline !== want.deadline)
          report_mismatch($sformatf("deadline %h want %h", got.deadline, want.deadline));
        if (got.last !== want.last)
          report_mismatch($sformatf("last %b want %b", got.last, want.last));
      end
      beats_checked++;
    end
  end

  always @(negedge clk_i) m_axis_tready <= ($urandom_range(99) >= idle_pct);

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles > StallLimit) begin
      $display("watchdog expired");
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic test_edges();
    send_item(KIND_RELEASE, 48'd0, 32'd0, 32'd0, 16'd0);
    send_item(KIND_RESERVE, 48'd0, 32'd0, 32'hFFFF_FFFF, 16'hFFFF);
    send_item(KIND_RESERVE, TickMax, 32'hFFFF_FFFF, 32'h1, 16'h1);
    send_item(KIND_RESERVE, 48'hFFFF_FFFF_0000, 32'h0001_0000, 32'h2, 16'h2);
    send_item(KIND_RESERVE, 48'd5, 32'd10, 32'h3, 16'h3);
    send_item(KIND_RESERVE, 48'd10, 32'd5, 32'h4, 16'h4);
    send_item(KIND_RELEASE, 48'd14, '0, '0, '0);
    send_item(KIND_RELEASE, 48'd15, '0, '0, '0);
    send_item(KIND_RELEASE, TickMax, '0, '0, '0);
    send_item(KIND_NONE, TickMax, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF);
    send_item(KIND_RESERVE, 48'd7, 32'd1, 32'hA5A5_5A5A, 16'h5A5A);
    send_item(KIND_CLEAR, TickMax, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF);
    send_item(KIND_RELEASE, TickMax, '0, '0, '0);
  endtask

  task automatic test_full_and_burst();
    for (int i = 0; i < Cap + 2; i++)
      send_item(KIND_RESERVE, 48'd100, $urandom_range(3), $urandom, 16'($urandom));
    send_item(KIND_RELEASE, 48'd103, '0, '0, '0);
    send_item(KIND_RELEASE, 48'd103, '0, '0, '0);
  endtask

  task automatic test_random_traffic();
    int r;
    for (int i = 0; i < 50; i++) begin
      if (i == 20) wait_drained();
      idle_pct = (i >= 30 && i < 45) ? 0 : 28;
      r = $urandom_range(99);
      clock_now = clock_now + $urandom_range(20);
      if (r < 3)
        send_item(KIND_RESERVE, 48'({$urandom, $urandom}), $urandom, $urandom,
                  16'($urandom));
      else if (r < 60)
        send_item(KIND_RESERVE, clock_now, $urandom_range(40), $urandom, 16'($urandom));
      else if (r < 62)
        send_item(KIND_RESERVE, clock_now, $urandom, $urandom, 16'($urandom));
      else if (r < 92)
        send_item(KIND_RELEASE, clock_now, $urandom, $urandom, 16'($urandom));
      else if (r < 96)
        send_item(KIND_CLEAR, 48'({$urandom, $urandom}), $urandom, $urandom,
                  16'($urandom));
      else
        send_item(KIND_NONE, 48'({$urandom, $urandom}), $urandom, $urandom,
                  16'($urandom));
    end
    idle_pct = 28;
    send_item(KIND_RELEASE, TickMax, '0, '0, '0);
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_edges();
    test_full_and_burst();
    test_random_traffic();
    wait_drained();
    repeat (200) @(posedge clk_i);
    $display("covered %0d items and %0d result beats: reserve, release, clear,", items_sent,
             beats_checked);
    $display("unused kind, full queue, saturated deadlines and bursts of due entries");
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
